// ----- sv/rod_pkg.sv -----
`default_nettype none

package rod_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int IDX_W    = 5;
    localparam int XLEN     = 32;
    localparam int OFFS_W   = 13;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 88;

    localparam logic ACT_DECODE = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    localparam logic [IDX_W-1:0] REG_A0 = 5'd10;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]         dest_reg;
        logic signed [XLEN-1:0]   operand_one;
        logic signed [XLEN-1:0]   operand_two;
        logic signed [OFFS_W-1:0] offset;
        logic                     illegal;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/rod_regfile.sv -----
`default_nettype none

module rod_regfile
    import rod_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_we,
    input  wire logic [IDX_W-1:0]       i_waddr,
    input  wire logic [XLEN-1:0]        i_wdata,
    input  wire logic                   i_re,
    input  wire logic [IDX_W-1:0]       i_raddr_a,
    input  wire logic [IDX_W-1:0]       i_raddr_b,
    output logic      [XLEN-1:0]        o_rdata_a,
    output logic      [XLEN-1:0]        o_rdata_b
);

    logic [XLEN-1:0]     mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [XLEN-1:0]     r_rd_a;
    logic [XLEN-1:0]     r_rd_b;
    logic                r_ok_a;
    logic                r_ok_b;
    logic                wr_ok;
    logic                ok_a;
    logic                ok_b;

    // x0 and numbers beyond the file never hold data
    assign wr_ok = i_we && (i_waddr != '0) && (32'(i_waddr) < NUM_REGS);
    assign ok_a  = (i_raddr_a != '0) && (32'(i_raddr_a) < NUM_REGS)
                   && r_valid[i_raddr_a[REG_AW-1:0]];
    assign ok_b  = (i_raddr_b != '0) && (32'(i_raddr_b) < NUM_REGS)
                   && r_valid[i_raddr_b[REG_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[i_waddr[REG_AW-1:0]] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= mem[i_raddr_a[REG_AW-1:0]];
            r_rd_b <= mem[i_raddr_b[REG_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ok_a  <= 1'b0;
            r_ok_b  <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_valid[i_waddr[REG_AW-1:0]] <= 1'b1;
            end
            if (i_re) begin
                r_ok_a <= ok_a;
                r_ok_b <= ok_b;
            end
        end
    end

    assign o_rdata_a = r_ok_a ? r_rd_a : '0;
    assign o_rdata_b = r_ok_b ? r_rd_b : '0;

endmodule

`default_nettype wire

// ----- sv/rod_decode.sv -----
`default_nettype none

module rod_decode
    import rod_pkg::*;
(
    input  wire logic [31:0]     i_instruction,
    input  wire logic [XLEN-1:0] i_rs1_value,
    input  wire logic [XLEN-1:0] i_rs2_value,
    output t_result              o_result
);

    logic [6:0]        opcode;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [IDX_W-1:0]  rd;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_u;
    logic [XLEN-1:0]   imm_j;
    logic [XLEN-1:0]   shamt;
    logic [OFFS_W-1:0] imm_s;
    logic [OFFS_W-1:0] imm_b;
    logic              bad;
    t_result           res;

    assign opcode = i_instruction[6:0];
    assign f3     = i_instruction[14:12];
    assign f7     = i_instruction[31:25];
    assign rd     = i_instruction[11:7];

    assign imm_i = {{20{i_instruction[31]}}, i_instruction[31:20]};
    assign imm_u = {{12{i_instruction[31]}}, i_instruction[31:12]};
    assign imm_j = {{11{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                    i_instruction[20], i_instruction[30:21], 1'b0};
    assign shamt = {26'd0, i_instruction[25:20]};
    assign imm_s = {i_instruction[31], i_instruction[31:25], i_instruction[11:7]};
    assign imm_b = {i_instruction[31], i_instruction[7], i_instruction[30:25],
                    i_instruction[11:8], 1'b0};

    always_comb begin
        res = '0;
        bad = 1'b0;
        case (opcode)
            OPC_OP: begin
                res.operand_one = i_rs1_value;
                res.operand_two = i_rs2_value;
                res.dest_reg    = rd;
                case (f3)
                    F3_ADD:  bad = !(f7 == F7_BASE || f7 == F7_MULDIV || f7 == F7_ALT);
                    F3_SLL:  bad = !(f7 == F7_BASE || f7 == F7_MULDIV);
                    F3_SLT:  bad = (f7 != F7_BASE);
                    F3_XOR:  bad = !(f7 == F7_BASE || f7 == F7_MULDIV);
                    F3_SR:   bad = !(f7 == F7_BASE || f7 == F7_ALT);
                    F3_OR:   bad = !(f7 == F7_BASE || f7 == F7_MULDIV);
                    F3_AND:  bad = (f7 != F7_BASE);
                    default: bad = 1'b1;
                endcase
            end
            OPC_OP_IMM: begin
                res.operand_one = i_rs1_value;
                res.dest_reg    = rd;
                res.operand_two = (f3 == F3_SLL || f3 == F3_SR) ? shamt : imm_i;
            end
            OPC_LUI, OPC_AUIPC: begin
                res.operand_one = imm_u;
                res.dest_reg    = rd;
            end
            OPC_JAL: begin
                res.operand_one = imm_j;
                res.dest_reg    = rd;
            end
            OPC_JALR: begin
                res.operand_one = i_rs1_value;
                res.operand_two = imm_i;
                res.dest_reg    = rd;
            end
            OPC_BRANCH: begin
                res.operand_one = i_rs1_value;
                res.operand_two = i_rs2_value;
                res.offset      = imm_b;
                bad             = (f3 == F3_SLT || f3 == F3_SLTU);
            end
            OPC_STORE: begin
                res.operand_one = i_rs1_value;
                res.operand_two = i_rs2_value;
                res.offset      = imm_s;
                bad             = f3[2];
            end
            OPC_LOAD: begin
                res.operand_one = i_rs1_value;
                res.operand_two = imm_i;
                res.dest_reg    = rd;
                bad             = (f3 == F3_OR || f3 == F3_AND);
            end
            OPC_SYSTEM: begin
                // rs1 port carries a0 here
                res.operand_one = i_rs1_value;
                bad             = !(f3 == F3_ADD && f7 == F7_BASE);
            end
            OPC_OP_IMM32: begin
                res.operand_one = i_rs1_value;
                res.operand_two = imm_i;
                res.dest_reg    = rd;
                bad             = (f3 != F3_ADD);
            end
            default: bad = 1'b1;
        endcase

        if (i_instruction[1:0] != 2'b11) begin
            bad = 1'b1;
        end
        if (bad) begin
            res = '0;
        end
        res.illegal = bad;
    end

    assign o_result = res;

endmodule

`default_nettype wire

// ----- sv/riscv_operand_decode.sv -----
// channel  dir  tdata (low bit up)                               tuser
// s_axis   in   instruction[31:0] write_index[36:32]             action
//               write_value[68:37], zero pad to 72
// m_axis   out  dest_reg[4:0] operand_one[36:5]                  illegal
//               operand_two[68:37] offset[81:69], zero pad to 88
//
// One request per cycle while m_axis_tready is high; an accepted decode
// request reaches its result through the registered read of the register
// file memory and then the output register.
// A write request gives no result and updates the file at its accept edge.
// Reset clears the per-entry valid flags; no clearing pass.
// A stalled output holds; s_axis_tready drops only when both stages are full.
`default_nettype none

module riscv_operand_decode
    import rod_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // instruction, write_index, write_value
    input  wire logic                 s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // dest_reg, operand_one, operand_two, offset
    output logic                      m_axis_tuser   // illegal
);

    logic [31:0]      in_instr;
    logic [IDX_W-1:0] in_widx;
    logic [XLEN-1:0]  in_wval;
    logic             accept;
    logic             do_write;
    logic             do_read;
    logic             out_free;
    logic [IDX_W-1:0] raddr_a;
    logic [XLEN-1:0]  rs1_value;
    logic [XLEN-1:0]  rs2_value;
    t_result          dec;

    logic             r_s1_valid;
    logic             n_s1_valid;
    logic [31:0]      r_s1_instr;
    logic             r_out_valid;
    logic             n_out_valid;
    t_result          r_out;

    assign in_instr = s_axis_tdata[31:0];
    assign in_widx  = s_axis_tdata[36:32];
    assign in_wval  = s_axis_tdata[68:37];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign do_write      = accept && (s_axis_tuser == ACT_WRITE);
    assign do_read       = accept && (s_axis_tuser == ACT_DECODE);

    assign raddr_a = (in_instr[6:0] == OPC_SYSTEM) ? REG_A0 : in_instr[19:15];

    rod_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (do_write),
        .i_waddr   (in_widx),
        .i_wdata   (in_wval),
        .i_re      (do_read),
        .i_raddr_a (raddr_a),
        .i_raddr_b (in_instr[24:20]),
        .o_rdata_a (rs1_value),
        .o_rdata_b (rs2_value)
    );

    rod_decode u_decode (
        .i_instruction (r_s1_instr),
        .i_rs1_value   (rs1_value),
        .i_rs2_value   (rs2_value),
        .o_result      (dec)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (do_read) begin
            n_s1_valid = 1'b1;
        end else if (out_free) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_s1_instr <= in_instr;
        end
        if (r_s1_valid && out_free) begin
            r_out <= dec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.offset, r_out.operand_two,
                            r_out.operand_one, r_out.dest_reg};
    assign m_axis_tuser  = r_out.illegal;

endmodule

`default_nettype wire

// ----- sv/rod_checker.sv -----
`default_nettype none

module rod_checker
    import rod_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("illegal result carries non-zero fields");

    a_offset_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[81:69] != '0 |-> m_axis_tdata[4:0] == '0)
        else $error("branch or store result has a destination");

endmodule

bind riscv_operand_decode rod_checker u_rod_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
